>>> rtl/fdw_pkg.sv
// ----------------------------------------------------------------------------
// fdw_pkg: shared types and constants of the dual FIFO weighted drain
//
// Sizes, command, status and turn codes, and the structs that travel
// between the top level and the row of storage cells.
// ----------------------------------------------------------------------------
package fdw_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 16;
    localparam int CMD_W      = 2;
    localparam int VALUE_W    = 16;
    localparam int CAP_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int TURN_W     = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    // Commands: bit 1 set means pop, whatever bit 0 holds
    localparam logic [CMD_W-1:0] CMD_PUSH_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_B = 2'd1;
    localparam int               CMD_POP_BIT = 1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED  = 2'd0,
        ST_POPPED  = 2'd1,
        ST_DROPPED = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // Turn codes: two A slots, then the B slot
    localparam logic [TURN_W-1:0] TURN_A1 = 2'd1;
    localparam logic [TURN_W-1:0] TURN_A2 = 2'd2;
    localparam logic [TURN_W-1:0] TURN_B  = 2'd3;

    // Slot tokens held by one cell, one bit per pointer
    typedef struct packed {
        logic head_a;
        logic tail_a;
        logic head_b;
        logic tail_b;
    } tok_t;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic                  adv_head_a;
        logic                  adv_tail_a;
        logic                  adv_head_b;
        logic                  adv_tail_b;
        logic [DATA_WIDTH-1:0] wdata;
    } cell_ctrl_t;

endpackage

>>> rtl/fdw_req_if.sv
// ----------------------------------------------------------------------------
// fdw_req_if: request channel of the dual FIFO weighted drain
//
// Carries one command and one data word per request.
// ----------------------------------------------------------------------------
interface fdw_req_if;

    logic                         valid;
    logic                         ready;
    logic [fdw_pkg::CMD_W-1:0]    command;
    logic [fdw_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);

endinterface

>>> rtl/fdw_rsp_if.sv
// ----------------------------------------------------------------------------
// fdw_rsp_if: result channel of the dual FIFO weighted drain
//
// Carries the popped word, its source queue, the status and both fills.
// ----------------------------------------------------------------------------
interface fdw_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [fdw_pkg::VALUE_W-1:0]   popped_value;
    logic                          src;
    logic [fdw_pkg::STATUS_W-1:0]  status;
    logic [fdw_pkg::CAP_W-1:0]     count_a;
    logic [fdw_pkg::CAP_W-1:0]     count_b;

    modport source (output valid, output popped_value, output src, output status,
                    output count_a, output count_b, input ready);
    modport sink   (input valid, input popped_value, input src, input status,
                    input count_a, input count_b, output ready);

endinterface

>>> rtl/fdw_cfg_if.sv
// ----------------------------------------------------------------------------
// fdw_cfg_if: configuration write channel of the dual FIFO weighted drain
//
// Carries the capacity register's write data.
// ----------------------------------------------------------------------------
interface fdw_cfg_if;

    logic                        valid;
    logic                        ready;
    logic [fdw_pkg::CAP_W-1:0]   capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);

endinterface

>>> rtl/fdw_cell.sv
// ----------------------------------------------------------------------------
// fdw_cell: one slot of both queues
//
// Holds the A and B words of its slot and the pointer tokens that sit on
// it. Tokens move to the next cell on an advance, or back to cell zero
// when this slot is the last one in use.
// ----------------------------------------------------------------------------
module fdw_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           home,
    input  logic                           wrap,
    input  fdw_pkg::cell_ctrl_t            ctrl,
    input  fdw_pkg::tok_t                  tok_in,
    output fdw_pkg::tok_t                  tok_pass,
    output fdw_pkg::tok_t                  tok_wrap,
    output logic [fdw_pkg::DATA_WIDTH-1:0] rd_a,
    output logic [fdw_pkg::DATA_WIDTH-1:0] rd_b
);

    // Tokens are kept relative to the home cell so that reset clears all
    fdw_pkg::tok_t                  tok_reg;
    fdw_pkg::tok_t                  tok_next;
    fdw_pkg::tok_t                  tok_cur;
    fdw_pkg::tok_t                  tok_upd;
    logic [fdw_pkg::DATA_WIDTH-1:0] data_a_reg;
    logic [fdw_pkg::DATA_WIDTH-1:0] data_b_reg;

    assign tok_cur = tok_reg ^ {4{home}};

    // Advance each token on its own strobe
    always_comb
    begin
        tok_upd.head_a = ctrl.adv_head_a ? tok_in.head_a : tok_cur.head_a;
        tok_upd.tail_a = ctrl.adv_tail_a ? tok_in.tail_a : tok_cur.tail_a;
        tok_upd.head_b = ctrl.adv_head_b ? tok_in.head_b : tok_cur.head_b;
        tok_upd.tail_b = ctrl.adv_tail_b ? tok_in.tail_b : tok_cur.tail_b;
        tok_next       = tok_upd ^ {4{home}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Write the pushed word into the slot that holds the tail token
    always_ff @(posedge clk)
    begin
        if (ctrl.adv_tail_a && tok_cur.tail_a)
        begin
            data_a_reg <= ctrl.wdata;
        end
        if (ctrl.adv_tail_b && tok_cur.tail_b)
        begin
            data_b_reg <= ctrl.wdata;
        end
    end

    // Hand tokens onward and gate the read words
    assign tok_pass = tok_cur & {4{~wrap}};
    assign tok_wrap = tok_cur & {4{wrap}};
    assign rd_a     = tok_cur.head_a ? data_a_reg : '0;
    assign rd_b     = tok_cur.head_b ? data_b_reg : '0;

endmodule

>>> rtl/dual_fifo_weighted_drain_top.sv
// ----------------------------------------------------------------------------
// dual_fifo_weighted_drain_top: two FIFOs drained in an A, A, B turn
//
// Top level: request handling, fill counts, turn and result register
// around a row of slot cells.
// ----------------------------------------------------------------------------
// The block takes one request per clock and gives one result per request,
// in the cycle after acceptance through an output register; it takes a new
// request in the same cycle as the waiting result is taken, so it
// sustains one request per cycle when the result side does not stall.
// Each of the sixteen cells holds slot i of both queues and the pointer
// tokens parked on it; a pointer moves by passing its token to the next
// cell, or back to cell zero past the last slot in use. Store contents are
// undefined until written and there is no clearing pass after reset.
// Capacity writes are to be taken only while the block is idle: a rule for the user, not enforced by the block.
module dual_fifo_weighted_drain_top (
    input  logic      clk,
    input  logic      rst_n,
    fdw_req_if.sink   req,
    fdw_rsp_if.source rsp,
    fdw_cfg_if.sink   cfg
);

    localparam int DEPTH = fdw_pkg::DEPTH;
    localparam int CW    = fdw_pkg::CAP_W;
    localparam int DW    = fdw_pkg::DATA_WIDTH;

    logic [CW-1:0]                cap_reg;
    logic [CW-1:0]                cap_use;
    logic [CW-1:0]                fill_a_reg;
    logic [CW-1:0]                fill_a_next;
    logic [CW-1:0]                fill_b_reg;
    logic [CW-1:0]                fill_b_next;
    logic [fdw_pkg::TURN_W-1:0]   turn_reg;
    logic [fdw_pkg::TURN_W-1:0]   turn_next;
    logic                         out_valid_reg;
    logic [fdw_pkg::VALUE_W-1:0]  popped_reg;
    logic [fdw_pkg::VALUE_W-1:0]  popped_next;
    logic                         source_reg;
    logic                         source_next;
    fdw_pkg::status_t             status_reg;
    fdw_pkg::status_t             status_next;

    logic                         accept;
    logic                         do_push_a;
    logic                         do_push_b;
    logic                         do_pop_a;
    logic                         do_pop_b;
    fdw_pkg::cell_ctrl_t          ctrl;

    logic                         wrap        [DEPTH];
    fdw_pkg::tok_t                tok_in      [DEPTH];
    fdw_pkg::tok_t                tok_pass    [DEPTH];
    fdw_pkg::tok_t                tok_wrap    [DEPTH];
    logic [DW-1:0]                rd_a        [DEPTH];
    logic [DW-1:0]                rd_b        [DEPTH];
    logic [DW-1:0]                head_word_a;
    logic [DW-1:0]                head_word_b;
    logic [DEPTH-1:0]             head_a_vec;

    // Clamp the capacity into the range the cells support
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_use = CW'(1);
        end
        else if (cap_reg > CW'(DEPTH))
        begin
            cap_use = CW'(DEPTH);
        end
        else
        begin
            cap_use = cap_reg;
        end
    end

    // Take a capacity write in any cycle
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= fdw_pkg::CAP_RESET;
        end
        else if (cfg.valid)
        begin
            cap_reg <= cfg.capacity;
        end
    end

    // Accept a request while the result register is free or being emptied
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Decide the step: push, drop, weighted pop or empty report
    always_comb
    begin
        logic [fdw_pkg::TURN_W-1:0] t;
        t           = turn_reg;
        do_push_a   = 1'b0;
        do_push_b   = 1'b0;
        do_pop_a    = 1'b0;
        do_pop_b    = 1'b0;
        turn_next   = turn_reg;
        popped_next = '0;
        source_next = 1'b0;
        status_next = fdw_pkg::ST_PUSHED;
        if (!req.command[fdw_pkg::CMD_POP_BIT])
        begin
            if (req.command == fdw_pkg::CMD_PUSH_A)
            begin
                if (fill_a_reg >= cap_use)
                begin
                    status_next = fdw_pkg::ST_DROPPED;
                end
                else
                begin
                    do_push_a = accept;
                end
            end
            else
            begin
                if (fill_b_reg >= cap_use)
                begin
                    status_next = fdw_pkg::ST_DROPPED;
                end
                else
                begin
                    do_push_b = accept;
                end
            end
        end
        else
        begin
            if (fill_a_reg == '0)
            begin
                t = fdw_pkg::TURN_B;
            end
            if (fill_b_reg == '0)
            begin
                t = fdw_pkg::TURN_A2;
            end
            if (fill_a_reg == '0 && fill_b_reg == '0)
            begin
                status_next = fdw_pkg::ST_EMPTY;
                turn_next   = fdw_pkg::TURN_A2;
            end
            else if (t == fdw_pkg::TURN_B)
            begin
                do_pop_b    = accept;
                popped_next = head_word_b;
                source_next = 1'b1;
                status_next = fdw_pkg::ST_POPPED;
                turn_next   = fdw_pkg::TURN_A1;
            end
            else
            begin
                do_pop_a    = accept;
                popped_next = head_word_a;
                status_next = fdw_pkg::ST_POPPED;
                turn_next   = t + fdw_pkg::TURN_W'(1);
            end
        end
    end

    // Update the fill counts
    always_comb
    begin
        fill_a_next = fill_a_reg;
        fill_b_next = fill_b_reg;
        if (do_push_a)
        begin
            fill_a_next = fill_a_reg + CW'(1);
        end
        else if (do_pop_a)
        begin
            fill_a_next = fill_a_reg - CW'(1);
        end
        if (do_push_b)
        begin
            fill_b_next = fill_b_reg + CW'(1);
        end
        else if (do_pop_b)
        begin
            fill_b_next = fill_b_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_a_reg <= '0;
            fill_b_reg <= '0;
            turn_reg   <= fdw_pkg::TURN_A1;
        end
        else if (accept)
        begin
            fill_a_reg <= fill_a_next;
            fill_b_reg <= fill_b_next;
            turn_reg   <= turn_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= popped_next;
            source_reg <= source_next;
            status_reg <= status_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = popped_reg;
    assign rsp.src          = source_reg;
    assign rsp.status       = status_reg;
    assign rsp.count_a      = fill_a_reg;
    assign rsp.count_b      = fill_b_reg;

    // Broadcast the step to the cells
    always_comb
    begin
        ctrl.adv_head_a = do_pop_a;
        ctrl.adv_tail_a = do_push_a;
        ctrl.adv_head_b = do_pop_b;
        ctrl.adv_tail_b = do_push_b;
        ctrl.wdata      = DW'(req.value);
    end

    // Row of slot cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign wrap[i] = (CW'(i + 1) >= cap_use);

        fdw_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .home     (i == 0),
            .wrap     (wrap[i]),
            .ctrl     (ctrl),
            .tok_in   (tok_in[i]),
            .tok_pass (tok_pass[i]),
            .tok_wrap (tok_wrap[i]),
            .rd_a     (rd_a[i]),
            .rd_b     (rd_b[i])
        );
    end

    // Link tokens along the row and fold wrapped tokens into cell zero
    always_comb
    begin
        fdw_pkg::tok_t wrap_or;
        wrap_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            wrap_or = wrap_or | tok_wrap[i];
        end
        tok_in[0] = wrap_or;
        for (int i = 1; i < DEPTH; i++)
        begin
            tok_in[i] = tok_pass[i-1];
        end
    end

    // Collect the head words and the head token map
    always_comb
    begin
        head_word_a = '0;
        head_word_b = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            head_word_a   = head_word_a | rd_a[i];
            head_word_b   = head_word_b | rd_b[i];
            head_a_vec[i] = tok_pass[i].head_a | tok_wrap[i].head_a;
        end
    end

    // Exactly one cell holds the head token of queue A
    a_head_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(head_a_vec))
        else $error("queue A head token lost or duplicated");

    // A fill never goes past the number of slots
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_a_reg <= CW'(DEPTH) && fill_b_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    // An accepted push to queue A with room raises its fill by one
    a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.command == fdw_pkg::CMD_PUSH_A && fill_a_reg < cap_use)
        |=> fill_a_reg == $past(fill_a_reg) + CW'(1))
        else $error("push to queue A did not raise its fill");

    // An empty report only comes when both queues were empty
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status_next == fdw_pkg::ST_EMPTY)
        |-> (fill_a_reg == '0 && fill_b_reg == '0))
        else $error("empty status with items queued");

endmodule

>>> test/fdw_drain_checker.sv
// ----------------------------------------------------------------------------
// fdw_drain_checker: result checker for the dual FIFO weighted drain
//
// Watches the request, result and capacity channels. Keeps its own copy of
// both queues, the turn and the capacity, predicts one result per accepted
// request and compares each accepted result field by field with the oldest
// prediction. Hands the mismatch count and the number of results still due
// to the testbench top.
// ----------------------------------------------------------------------------
module fdw_drain_checker
    import fdw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fdw_req_if   req,
    fdw_rsp_if   rsp,
    fdw_cfg_if   cfg,
    output int   errors,
    output int   pending
);

    typedef struct {
        logic [VALUE_W-1:0] word;
        logic               src;
        status_t            status;
        logic [CAP_W-1:0]   cnt_a;
        logic [CAP_W-1:0]   cnt_b;
    } drain_result_t;

    // Queue copies: index 0 is queue A, index 1 is queue B
    logic [DATA_WIDTH-1:0] slot_mem [2][DEPTH];
    int                    head [2];
    int                    tail [2];
    int                    fill [2];
    logic [TURN_W-1:0]     turn;
    logic [CAP_W-1:0]      capacity;

    drain_result_t expected_results [$];

    // Clamp the capacity register to the range the queues can use
    function automatic int cap_in_use();
        if (capacity == '0)
            return 1;
        if (int'(capacity) > DEPTH)
            return DEPTH;
        return int'(capacity);
    endfunction

    // Advance a slot pointer, wrapping at or past the capacity in use
    function automatic int next_slot(input int p);
        return (p + 1 >= cap_in_use()) ? 0 : p + 1;
    endfunction

    // Apply one request to the queue copies and work out its result
    task automatic serve_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                                 output drain_result_t r);
        int q;
        r.word = '0;
        r.src  = 1'b0;
        if (!cmd[CMD_POP_BIT])
        begin
            q = (cmd == CMD_PUSH_A) ? 0 : 1;
            if (fill[q] >= cap_in_use())
                r.status = ST_DROPPED;
            else
            begin
                slot_mem[q][tail[q]] = val;
                tail[q] = next_slot(tail[q]);
                fill[q]++;
                r.status = ST_PUSHED;
            end
        end
        else
        begin
            // Force the turn away from an empty queue; empty B wins
            if (fill[0] == 0)
                turn = TURN_B;
            if (fill[1] == 0)
                turn = TURN_A2;
            if (fill[0] == 0 && fill[1] == 0)
                r.status = ST_EMPTY;
            else
            begin
                q = (turn == TURN_B) ? 1 : 0;
                r.word = slot_mem[q][head[q]];
                head[q] = next_slot(head[q]);
                fill[q]--;
                r.src = (q == 1);
                r.status = ST_POPPED;
                if (q == 1)
                    turn = TURN_A1;
                else
                    turn = turn + 1'b1;
            end
        end
        r.cnt_a = CAP_W'(fill[0]);
        r.cnt_b = CAP_W'(fill[1]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Track capacity writes, check results, then predict new requests
    always @(posedge clk or negedge rst_n)
    begin
        drain_result_t due;
        drain_result_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                head[i] = 0;
                tail[i] = 0;
                fill[i] = 0;
            end
            turn     = TURN_A1;
            capacity = CAP_RESET;
            expected_results.delete();
            errors   = 0;
            pending  = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                capacity = cfg.capacity;

            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request due, expected none, got status %0d",
                             $time, rsp.status);
                end
                else
                begin
                    due = expected_results.pop_front();
                    check_field("popped_value", due.word, rsp.popped_value);
                    check_field("source", due.src, rsp.src);
                    check_field("status", due.status, rsp.status);
                    check_field("count_a", due.cnt_a, rsp.count_a);
                    check_field("count_b", due.cnt_b, rsp.count_b);
                end
            end

            if (req.valid && req.ready)
            begin
                serve_request(req.command, req.value, fresh);
                expected_results.push_back(fresh);
            end

            pending = expected_results.size();
        end
    end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench top for the dual FIFO weighted drain
//
// Drives requests and capacity writes into the block, stalls both sides at
// random, and gives the verdict from the checker's mismatch count. Starts
// with directed requests and a full fill and drain of both queues, then
// runs random request mixes under a range of capacity settings.
// ----------------------------------------------------------------------------
module tb_top;

    import fdw_pkg::*;

    localparam int ITEMS_PER_SEGMENT = 240;
    localparam int SEGMENTS          = 8;
    localparam int CYCLE_LIMIT       = 400000;

    // Pop codes: bit 1 selects pop, bit 0 is ignored
    localparam logic [CMD_W-1:0] CMD_POP    = 2'b10;
    localparam logic [CMD_W-1:0] CMD_POP_HI = 2'b11;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   rcv_idle_pct;
    int   cycles = 0;
    int   errors;
    int   pending;

    fdw_req_if req_ch ();
    fdw_rsp_if rsp_ch ();
    fdw_cfg_if cfg_ch ();

    dual_fifo_weighted_drain_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    fdw_drain_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Stop a run that hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stall the result side at random
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);

    // Send one request, idling the sender at random first
    task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.value   <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Write the capacity once every result due has come out
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.capacity <= cap;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [CMD_W-1:0] pick_pop();
        return ($urandom_range(7) == 0) ? CMD_POP_HI : CMD_POP;
    endfunction

    function automatic logic [CAP_W-1:0] segment_capacity(input int seg);
        case (seg)
            0:       return CAP_W'(1);
            1:       return '0;
            2:       return '1;
            3:       return CAP_W'(2);
            4:       return CAP_RESET;
            5:       return CAP_W'($urandom_range(3, 15));
            6:       return CAP_W'($urandom_range(0, 31));
            default: return CAP_RESET;
        endcase
    endfunction

    initial
    begin
        int push_pct;
        req_ch.valid    = 1'b0;
        req_ch.command  = CMD_PUSH_A;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.capacity = '0;
        src_idle_pct    = 27;
        rcv_idle_pct    = 82;
        rst_n           = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Pop both empty, extremes of the data word, forced turns
        issue_request(CMD_POP, 16'h0000);
        issue_request(CMD_POP_HI, 16'hFFFF);
        issue_request(CMD_PUSH_A, 16'h0000);
        issue_request(CMD_PUSH_A, 16'hFFFF);
        issue_request(CMD_PUSH_B, 16'hA5A5);
        issue_request(CMD_PUSH_B, 16'h5A5A);
        issue_request(CMD_POP, 16'hFFFF);
        issue_request(CMD_POP, 16'h0000);
        issue_request(CMD_POP_HI, 16'h0000);
        issue_request(CMD_POP, 16'h0000);
        issue_request(CMD_POP, 16'h0000);
        issue_request(CMD_PUSH_B, 16'h1234);
        issue_request(CMD_POP, 16'h0000);
        issue_request(CMD_PUSH_A, 16'h8001);
        issue_request(CMD_POP, 16'h0000);

        // Fill both queues past full, then drain past empty; this writes
        // every slot, so later capacity changes never pop an unwritten one
        repeat (DEPTH + 1) issue_request(CMD_PUSH_A, VALUE_W'($urandom));
        repeat (DEPTH + 1) issue_request(CMD_PUSH_B, VALUE_W'($urandom));
        repeat (2 * DEPTH + 1) issue_request(pick_pop(), VALUE_W'($urandom));

        // Random mixes, one capacity setting per segment
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 3)
            begin
                src_idle_pct = 27;
                rcv_idle_pct = 82;
            end
            else if (seg < 6)
            begin
                src_idle_pct = 82;
                rcv_idle_pct = 27;
            end
            else
            begin
                src_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            write_capacity(segment_capacity(seg));
            push_pct = $urandom_range(30, 70);
            for (int n = 0; n < ITEMS_PER_SEGMENT; n++)
            begin
                if ($urandom_range(99) < push_pct)
                    issue_request($urandom_range(1) ? CMD_PUSH_B : CMD_PUSH_A,
                                  VALUE_W'($urandom));
                else
                    issue_request(pick_pop(), VALUE_W'($urandom));
            end
        end

        // Drain the results still due, then let the pipeline settle
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
